>>> hdl/sqw_pkg.sv
// Shared types, codes and tables of the square-wave sound channel.
`timescale 1ns / 1ps
package sqw_pkg;

   localparam logic [2:0] CMD_WRITE  = 3'd0;
   localparam logic [2:0] CMD_ENABLE = 3'd1;
   localparam logic [2:0] CMD_ENV    = 3'd2;
   localparam logic [2:0] CMD_SWEEP  = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   localparam logic [1:0] CSR_RATE   = 2'd0;
   localparam logic [1:0] CSR_SCALE  = 2'd1;
   localparam logic [1:0] CSR_NEGATE = 2'd2;

   localparam logic [1:0] REG_ENV    = 2'd0;
   localparam logic [1:0] REG_SWEEP  = 2'd1;
   localparam logic [1:0] REG_LOW    = 2'd2;
   localparam logic [1:0] REG_HIGH   = 2'd3;

   localparam logic [10:0] PERIOD_MIN = 11'h008;
   localparam logic [11:0] PERIOD_MAX = 12'h7ff;
   localparam logic [15:0] DECAY_STEP = 16'd63;
   localparam logic [17:0] TIMER_INIT = 18'd2048;
   localparam logic [15:0] STEP_INIT  = 16'd2;

   typedef enum logic [5:0] {
      OP_WRITE  = 6'b000001,
      OP_ENABLE = 6'b000010,
      OP_ENV    = 6'b000100,
      OP_SWEEP  = 6'b001000,
      OP_TICK   = 6'b010000,
      OP_NONE   = 6'b100000
   } sqw_op_kind_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [1:0] reg_index;
      logic [7:0] write_data;
      logic       enable_flag;
      logic       length_force;
   } sqw_req_type;

   typedef struct packed {
      logic [15:0] amplitude;
      logic        length_nonzero;
   } sqw_rsp_type;

   typedef struct packed {
      sqw_op_kind_type kind;
      logic [1:0]      reg_index;
      logic [7:0]      write_data;
      logic            enable_flag;
      logic            length_force;
   } sqw_op_type;

   localparam logic [7:0] DUTY_MASK [4] = '{8'hfd, 8'hf9, 8'he1, 8'h06};

   localparam logic [7:0] LENGTH_TABLE [32] = '{
      8'h0a, 8'hfe, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
      8'ha0, 8'h08, 8'h3c, 8'h0a, 8'h0e, 8'h0c, 8'h1a, 8'h0e,
      8'h0c, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
      8'hc0, 8'h18, 8'h48, 8'h1a, 8'h10, 8'h1c, 8'h20, 8'h1e
   };

endpackage

>>> hdl/square_wave_sound_channel_core.sv
// Top level of the square-wave sound channel: front queue and execution back end.
//
//   channel   ports                          transaction when
//   request   req_push req_full req_item     push high and full low
//   response  rsp_pop rsp_empty rsp_item     pop high and empty low
//   control   csr_we csr_index csr_wdata     write enable high
//
// Commands other than a sample tick pass through S_IDLE and S_PUT in the back end.
// A tick does the same when the timer stays non-negative; otherwise it also steps
// periods in S_LOOP and, when the channel is active, then runs the multiply in S_MUL
// and the restoring divider in S_DIV. The 4-entry command queue keeps accepting while the
// back end works; a finished result waits in the output register.
// Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
module square_wave_sound_channel_core import sqw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  sqw_req_type req_item,
   output logic        req_full,
   output logic        rsp_empty,
   output sqw_rsp_type rsp_item,
   input  logic        rsp_pop,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic       op_valid;
   logic       op_pop;
   sqw_op_type op_item;

   sqw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .op_valid (op_valid),
      .op_item  (op_item),
      .op_pop   (op_pop)
   );

   sqw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_valid  (op_valid),
      .op_item   (op_item),
      .op_pop    (op_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item),
      .rsp_pop   (rsp_pop)
   );

endmodule

>>> hdl/sqw_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module sqw_front import sqw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  sqw_req_type req_item,
   output logic        req_full,
   output logic        op_valid,
   output sqw_op_type  op_item,
   input  logic        op_pop
);

   sqw_op_type q_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       push_ok, pop_ok;
   sqw_op_type op_new;

   always_comb begin
      case (req_item.cmd) inside
         CMD_WRITE:  op_new.kind = OP_WRITE;
         CMD_ENABLE: op_new.kind = OP_ENABLE;
         CMD_ENV:    op_new.kind = OP_ENV;
         CMD_SWEEP:  op_new.kind = OP_SWEEP;
         CMD_TICK:   op_new.kind = OP_TICK;
         default:    op_new.kind = OP_NONE;
      endcase
      op_new.reg_index    = req_item.reg_index;
      op_new.write_data   = req_item.write_data;
      op_new.enable_flag  = req_item.enable_flag;
      op_new.length_force = req_item.length_force;
   end

   assign req_full = count_ff == 3'd4;
   assign op_valid = count_ff != 3'd0;
   assign op_item  = q_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = op_pop && op_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      count_in  = count_ff + {2'd0, push_ok} - {2'd0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

>>> hdl/sqw_back.sv
// Back end: channel state, command execution, sample synthesis and result register.
`timescale 1ns / 1ps
module sqw_back import sqw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        op_valid,
   input  sqw_op_type  op_item,
   output logic        op_pop,
   output logic        rsp_empty,
   output sqw_rsp_type rsp_item,
   input  logic        rsp_pop
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOOP = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_PUT  = 5'b10000
   } state_type;

   logic [15:0] rate_ff;
   logic [3:0]  scale_ff;
   logic        negone_ff;

   state_type   state_ff, state_in;
   logic [3:0]  env_base_ff, env_base_in, env_vol_ff, env_vol_in, env_div_ff, env_div_in;
   logic [11:0] env_out_ff, env_out_in;
   logic        env_const_ff, env_const_in, env_loop_ff, env_loop_in;
   logic        env_restart_ff, env_restart_in;
   logic        len_en_ff, len_en_in;
   logic [7:0]  len_ff, len_in;
   logic [10:0] period_ff, period_in;
   logic        pvalid_ff, pvalid_in;
   logic [15:0] step_len_ff, step_len_in;
   logic signed [17:0] timer_ff, timer_in;
   logic [15:0] held_ff, held_in;
   logic [2:0]  duty_step_ff, duty_step_in;
   logic [1:0]  duty_sel_ff, duty_sel_in;
   logic [3:0]  sw_period_ff, sw_period_in, sw_div_ff, sw_div_in;
   logic        sw_reload_ff, sw_reload_in, sw_add_ff, sw_add_in;
   logic [2:0]  sw_shift_ff, sw_shift_in;
   logic        act_ff, act_in;
   logic [16:0] sum_ff, sum_in;
   logic [29:0] dvd_ff, dvd_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] amp_ff, amp_in;
   logic        out_valid_ff, out_valid_in;
   sqw_rsp_type out_ff, out_in;

   logic [15:0] rate_e, freq;
   logic [3:0]  scale_e;
   logic        active;
   logic signed [17:0] t_dec, t_inc, t_neg;
   logic [16:0] v_step;
   logic [2:0]  step_nx;
   logic [16:0] rem_sh;
   logic [10:0] sh_val, p_sw;
   logic [16:0] upd_res;
   logic [3:0]  vol_sel;

   function automatic logic duty_high(input logic [1:0] sel, input logic [2:0] step);
      logic [7:0] m;
      m = DUTY_MASK[sel];
      return !m[step];
   endfunction

   // {valid, step length} for a candidate period
   function automatic logic [16:0] upd(input logic [10:0] p, input logic add,
                                       input logic [2:0] sh, input logic [3:0] sc);
      logic [11:0] tot;
      logic [16:0] prod;
      tot  = {1'b0, p} + (add ? {1'b0, p >> sh} : 12'd0);
      prod = 17'({1'b0, p} + 12'd1) * 17'(sc);
      return {(p >= PERIOD_MIN) && (tot <= PERIOD_MAX), prod[14:0], 1'b0};
   endfunction

   assign rate_e  = (rate_ff == 16'd0) ? 16'd1 : rate_ff;
   assign scale_e = (scale_ff == 4'd0) ? 4'd1 : scale_ff;
   assign freq    = (step_len_ff == 16'd0) ? 16'd1 : step_len_ff;
   assign active  = (len_ff != 8'd0) && (env_out_ff != 12'd0) && pvalid_ff;
   assign t_dec   = timer_ff - $signed({2'b00, rate_e});
   assign t_inc   = timer_ff + $signed({2'b00, freq});
   assign t_neg   = -timer_ff;
   assign v_step  = (t_neg[16:0] > {1'b0, freq}) ? {1'b0, freq} : t_neg[16:0];
   assign step_nx = duty_step_ff + 3'd1;
   assign rem_sh  = {rem_ff, dvd_ff[29]};

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      state_in       = state_ff;
      env_base_in    = env_base_ff;
      env_vol_in     = env_vol_ff;
      env_div_in     = env_div_ff;
      env_out_in     = env_out_ff;
      env_const_in   = env_const_ff;
      env_loop_in    = env_loop_ff;
      env_restart_in = env_restart_ff;
      len_en_in      = len_en_ff;
      len_in         = len_ff;
      period_in      = period_ff;
      pvalid_in      = pvalid_ff;
      step_len_in    = step_len_ff;
      timer_in       = timer_ff;
      held_in        = held_ff;
      duty_step_in   = duty_step_ff;
      duty_sel_in    = duty_sel_ff;
      sw_period_in   = sw_period_ff;
      sw_div_in      = sw_div_ff;
      sw_reload_in   = sw_reload_ff;
      sw_add_in      = sw_add_ff;
      sw_shift_in    = sw_shift_ff;
      act_in         = act_ff;
      sum_in         = sum_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      amp_in         = amp_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_in         = out_ff;
      op_pop         = 1'b0;
      sh_val         = 11'd0;
      p_sw           = 11'd0;
      upd_res        = 17'd0;
      vol_sel        = 4'd0;

      case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               op_pop   = 1'b1;
               amp_in   = 16'd0;
               state_in = S_PUT;
               case (op_item.kind)
                  OP_WRITE: begin
                     case (op_item.reg_index)
                        REG_ENV: begin
                           env_base_in  = op_item.write_data[3:0];
                           env_const_in = op_item.write_data[4];
                           env_loop_in  = op_item.write_data[5];
                           duty_sel_in  = op_item.write_data[7:6];
                           vol_sel      = op_item.write_data[4] ? op_item.write_data[3:0]
                                                                : env_vol_ff;
                           env_out_in   = {vol_sel, 8'd0};
                        end
                        REG_SWEEP: begin
                           sw_add_in    = !op_item.write_data[3];
                           sw_shift_in  = op_item.write_data[2:0];
                           sw_period_in = 4'd0;
                           if (op_item.write_data[7] && op_item.write_data[2:0] != 3'd0) begin
                              sw_period_in = {1'b0, op_item.write_data[6:4]} + 4'd1;
                              sw_reload_in = 1'b1;
                           end
                           upd_res = upd(period_ff, !op_item.write_data[3],
                                         op_item.write_data[2:0], scale_e);
                        end
                        REG_LOW: begin
                           period_in = {period_ff[10:8], op_item.write_data};
                           upd_res   = upd(period_in, sw_add_ff, sw_shift_ff, scale_e);
                        end
                        default: begin
                           period_in = {op_item.write_data[2:0], period_ff[7:0]};
                           upd_res   = upd(period_in, sw_add_ff, sw_shift_ff, scale_e);
                           env_restart_in = 1'b1;
                           if (op_item.length_force || len_ff == 8'd0) begin
                              len_in = len_en_ff ? LENGTH_TABLE[op_item.write_data[7:3]] : 8'd0;
                           end
                           duty_step_in = 3'd0;
                        end
                     endcase
                     if (op_item.reg_index != REG_ENV) begin
                        pvalid_in = upd_res[16];
                        if (upd_res[16]) begin
                           step_len_in = upd_res[15:0];
                        end
                     end
                  end
                  OP_ENABLE: begin
                     len_en_in = op_item.enable_flag;
                     if (!op_item.enable_flag) begin
                        len_in = 8'd0;
                     end
                  end
                  OP_ENV: begin
                     if (env_restart_ff) begin
                        env_restart_in = 1'b0;
                        env_vol_in     = 4'hf;
                        env_div_in     = env_base_ff;
                     end else if (env_div_ff != 4'd0) begin
                        env_div_in = env_div_ff - 4'd1;
                     end else begin
                        if (env_vol_ff != 4'd0 || env_loop_ff) begin
                           env_vol_in = env_vol_ff - 4'd1;
                        end
                        env_div_in = env_base_ff;
                     end
                     vol_sel    = env_const_ff ? env_base_ff : env_vol_in;
                     env_out_in = {vol_sel, 8'd0};
                  end
                  OP_SWEEP: begin
                     if (!env_loop_ff && len_ff != 8'd0) begin
                        len_in = len_ff - 8'd1;
                     end
                     if (sw_period_ff != 4'd0) begin
                        sw_div_in = sw_div_ff - 4'd1;
                        if (sw_div_in == 4'd0) begin
                           sw_div_in = sw_period_ff;
                           if (period_ff >= PERIOD_MIN) begin
                              sh_val = period_ff >> sw_shift_ff;
                              if (!sw_add_ff) begin
                                 p_sw    = period_ff - sh_val - {10'd0, negone_ff};
                                 upd_res = upd(p_sw, sw_add_ff, sw_shift_ff, scale_e);
                                 period_in = p_sw;
                                 pvalid_in = upd_res[16];
                                 if (upd_res[16]) begin
                                    step_len_in = upd_res[15:0];
                                 end
                              end else if (({1'b0, period_ff} + {1'b0, sh_val}) <= PERIOD_MAX) begin
                                 p_sw    = period_ff + sh_val;
                                 upd_res = upd(p_sw, sw_add_ff, sw_shift_ff, scale_e);
                                 period_in = p_sw;
                                 pvalid_in = upd_res[16];
                                 if (upd_res[16]) begin
                                    step_len_in = upd_res[15:0];
                                 end
                              end
                           end
                        end
                     end
                     if (sw_reload_ff) begin
                        sw_reload_in = 1'b0;
                        sw_div_in    = sw_period_ff;
                     end
                  end
                  OP_TICK: begin
                     timer_in = t_dec;
                     act_in   = active;
                     sum_in   = (timer_ff > 18'sd0 && duty_high(duty_sel_ff, duty_step_ff))
                                ? timer_ff[16:0] : 17'd0;
                     if (t_dec < 18'sd0) begin
                        state_in = S_LOOP;
                     end else if (active) begin
                        held_in = duty_high(duty_sel_ff, duty_step_ff) ? {4'd0, env_out_ff}
                                                                        : 16'd0;
                        amp_in  = held_in;
                     end else if (held_ff >= DECAY_STEP) begin
                        held_in = held_ff - DECAY_STEP;
                        amp_in  = held_in;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOOP: begin
            // one period step per cycle until the timer is back at or above zero
            duty_step_in = step_nx;
            if (act_ff && duty_high(duty_sel_ff, step_nx)) begin
               sum_in = sum_ff + v_step;
            end
            timer_in = t_inc;
            if (t_inc >= 18'sd0) begin
               if (act_ff) begin
                  state_in = S_MUL;
               end else begin
                  state_in = S_PUT;
                  amp_in   = 16'd0;
                  if (held_ff >= DECAY_STEP) begin
                     held_in = held_ff - DECAY_STEP;
                     amp_in  = held_in;
                  end
               end
            end
         end
         S_MUL: begin
            dvd_in   = ({13'd0, sum_ff} * {18'd0, env_out_ff}) + {15'd0, rate_e[15:1]};
            rem_in   = 16'd0;
            cnt_in   = 5'd29;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {1'b0, rate_e}) begin
               rem_in = 16'(rem_sh - {1'b0, rate_e});
               dvd_in = {dvd_ff[28:0], 1'b1};
            end else begin
               rem_in = rem_sh[15:0];
               dvd_in = {dvd_ff[28:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               held_in  = dvd_in[15:0];
               amp_in   = dvd_in[15:0];
               state_in = S_PUT;
            end
         end
         S_PUT: begin
            // hold the result until the output register frees up
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in             = 1'b1;
               out_in.amplitude         = amp_ff;
               out_in.length_nonzero    = len_ff != 8'd0;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= 16'd1;
         scale_ff  <= 4'd1;
         negone_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE:   rate_ff   <= csr_wdata;
            CSR_SCALE:  scale_ff  <= csr_wdata[3:0];
            CSR_NEGATE: negone_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         env_base_ff    <= '0;
         env_vol_ff     <= '0;
         env_div_ff     <= '0;
         env_out_ff     <= '0;
         env_const_ff   <= 1'b1;
         env_loop_ff    <= 1'b0;
         env_restart_ff <= 1'b0;
         len_en_ff      <= 1'b0;
         len_ff         <= '0;
         period_ff      <= '0;
         pvalid_ff      <= 1'b0;
         step_len_ff    <= STEP_INIT;
         timer_ff       <= $signed(TIMER_INIT);
         held_ff        <= '0;
         duty_step_ff   <= '0;
         duty_sel_ff    <= '0;
         sw_period_ff   <= '0;
         sw_div_ff      <= 4'd1;
         sw_reload_ff   <= 1'b0;
         sw_add_ff      <= 1'b1;
         sw_shift_ff    <= '0;
         act_ff         <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         env_base_ff    <= env_base_in;
         env_vol_ff     <= env_vol_in;
         env_div_ff     <= env_div_in;
         env_out_ff     <= env_out_in;
         env_const_ff   <= env_const_in;
         env_loop_ff    <= env_loop_in;
         env_restart_ff <= env_restart_in;
         len_en_ff      <= len_en_in;
         len_ff         <= len_in;
         period_ff      <= period_in;
         pvalid_ff      <= pvalid_in;
         step_len_ff    <= step_len_in;
         timer_ff       <= timer_in;
         held_ff        <= held_in;
         duty_step_ff   <= duty_step_in;
         duty_sel_ff    <= duty_sel_in;
         sw_period_ff   <= sw_period_in;
         sw_div_ff      <= sw_div_in;
         sw_reload_ff   <= sw_reload_in;
         sw_add_ff      <= sw_add_in;
         sw_shift_ff    <= sw_shift_in;
         act_ff         <= act_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      amp_ff <= amp_in;
      out_ff <= out_in;
   end

endmodule
